[rtl/core/first_fit_extent_allocator_core_macros.svh]
// ----------------------------------------------------------------------------
// first fit extent allocator assertion macros
// concurrent assertion wrappers, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FFEA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FFEA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define FFEA_ASSERT(label, clk, rst_n, prop, msg)
`define FFEA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/core/ffea_pkg.sv]
// ----------------------------------------------------------------------------
// ffea_pkg
// shared types, codes and constants of the first fit extent allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ffea_pkg;

  localparam int unsigned AddrBits      = 32;
  localparam int unsigned DefMaxExtents = 16;
  localparam int unsigned DefMaxBlocks  = 32;

  typedef logic [AddrBits-1:0] aw_t;
  typedef logic [AddrBits:0]   aw1_t;

  // command codes
  localparam logic [1:0] CMD_ALLOC    = 2'd0;
  localparam logic [1:0] CMD_ALLOC_AT = 2'd1;
  localparam logic [1:0] CMD_RELEASE  = 2'd2;
  localparam logic [1:0] CMD_RESERVE  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OOM      = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_EXT_FULL = 2'd3;

  // datapath micro operations
  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_BSCAN, OP_BDEC, OP_FIT, OP_FITDEC, OP_FITAT, OP_FITW,
    OP_REC, OP_RECW, OP_GBP, OP_GBPD, OP_GBN, OP_GBND, OP_GBL, OP_GBLD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_ctl_t;

  typedef struct packed {
    logic       ext_last;
    logic       blk_last;
    logic [1:0] cmd;
    logic       size_zero;
    logic       any_mode;
    logic       blk_full;
    logic       found;
    logic       fit_hit;
    logic       fit_split;
    logic       bump_fail;
  } dp_sts_t;

endpackage

[rtl/core/ffea_ctrl.sv]
// ----------------------------------------------------------------------------
// ffea_ctrl
// sequencer of table scans and update steps for one command word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_core_macros.svh"

module ffea_ctrl
  import ffea_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  dp_sts_t sts_i,
  output dp_ctl_t ctl_o,
  output logic    busy_o,
  output logic    done_o
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_BSCAN  = 5'd2;
  localparam logic [4:0] S_BDEC   = 5'd3;
  localparam logic [4:0] S_FIT    = 5'd4;
  localparam logic [4:0] S_FITDEC = 5'd5;
  localparam logic [4:0] S_FITAT  = 5'd6;
  localparam logic [4:0] S_FITW   = 5'd7;
  localparam logic [4:0] S_REC    = 5'd8;
  localparam logic [4:0] S_RECW   = 5'd9;
  localparam logic [4:0] S_GBP    = 5'd10;
  localparam logic [4:0] S_GBPD   = 5'd11;
  localparam logic [4:0] S_GBN    = 5'd12;
  localparam logic [4:0] S_GBND   = 5'd13;
  localparam logic [4:0] S_GBL    = 5'd14;
  localparam logic [4:0] S_GBLD   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d   = state_q;
    ctl_o.op  = OP_NOP;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.op = OP_LOAD;
          state_d  = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.cmd == CMD_RESERVE) begin
          state_d = sts_i.size_zero ? S_DONE : S_FIT;
        end else begin
          state_d = S_BSCAN;
        end
      end
      S_BSCAN: begin
        ctl_o.op = OP_BSCAN;
        if (sts_i.blk_last) state_d = S_BDEC;
      end
      S_BDEC: begin
        ctl_o.op = OP_BDEC;
        if (sts_i.cmd == CMD_RELEASE) begin
          state_d = sts_i.found ? S_GBP : S_DONE;
        end else if (!sts_i.blk_full && sts_i.any_mode) begin
          state_d = S_FIT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FIT: begin
        ctl_o.op = OP_FIT;
        if (sts_i.ext_last) state_d = S_FITDEC;
      end
      S_FITDEC: begin
        ctl_o.op = OP_FITDEC;
        if (sts_i.fit_hit && sts_i.fit_split) begin
          state_d = S_FITAT;
        end else if (!sts_i.fit_hit && sts_i.bump_fail) begin
          state_d = S_DONE;
        end else begin
          state_d = (sts_i.cmd == CMD_RESERVE) ? S_DONE : S_REC;
        end
      end
      S_FITAT: begin
        ctl_o.op = OP_FITAT;
        if (sts_i.ext_last) state_d = S_FITW;
      end
      S_FITW: begin
        ctl_o.op = OP_FITW;
        state_d  = (sts_i.cmd == CMD_RESERVE) ? S_DONE : S_REC;
      end
      S_REC: begin
        ctl_o.op = OP_REC;
        if (sts_i.blk_last) state_d = S_RECW;
      end
      S_RECW: begin
        ctl_o.op = OP_RECW;
        state_d  = S_DONE;
      end
      S_GBP: begin
        ctl_o.op = OP_GBP;
        if (sts_i.ext_last) state_d = S_GBPD;
      end
      S_GBPD: begin
        ctl_o.op = OP_GBPD;
        state_d  = S_GBN;
      end
      S_GBN: begin
        ctl_o.op = OP_GBN;
        if (sts_i.ext_last) state_d = S_GBND;
      end
      S_GBND: begin
        ctl_o.op = OP_GBND;
        state_d  = S_GBL;
      end
      S_GBL: begin
        ctl_o.op = OP_GBL;
        if (sts_i.ext_last) state_d = S_GBLD;
      end
      S_GBLD: begin
        ctl_o.op = OP_GBLD;
        state_d  = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  `FFEA_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o, "start not taken")
  `FFEA_ASSERT_NEXT(a_done_idle, clk_i, rst_ni, done_o, !busy_o, "no idle after done")
  `FFEA_ASSERT_NEXT(a_busy_hold, clk_i, rst_ni, busy_o && !done_o, busy_o, "busy dropped early")

endmodule

[rtl/core/ffea_datapath.sv]
// ----------------------------------------------------------------------------
// ffea_datapath
// extent and block tables, scan accumulators and update logic
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "first_fit_extent_allocator_core_macros.svh"

module ffea_datapath
  import ffea_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = DefMaxExtents,
  parameter int unsigned MAX_BLOCKS  = DefMaxBlocks
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] cmd_i,
  input  aw_t        request_size_i,
  input  aw_t        target_address_i,
  input  dp_ctl_t    ctl_i,
  output dp_sts_t    sts_o,
  output aw_t        result_address_o,
  output logic [1:0] status_o
);

  localparam int unsigned EIW = $clog2(MAX_EXTENTS);
  localparam int unsigned BIW = $clog2(MAX_BLOCKS);
  localparam int unsigned CW  = (EIW > BIW) ? EIW : BIW;
  localparam aw1_t AddrLimit  = {1'b1, {AddrBits{1'b0}}};

  // tables
  aw1_t nfa_q, nfa_d;
  aw_t  ext_start_q [MAX_EXTENTS];
  aw_t  ext_start_d [MAX_EXTENTS];
  aw_t  ext_len_q   [MAX_EXTENTS];
  aw_t  ext_len_d   [MAX_EXTENTS];
  logic [MAX_EXTENTS-1:0] ext_vld_q, ext_vld_d;
  aw_t  blk_start_q [MAX_BLOCKS];
  aw_t  blk_start_d [MAX_BLOCKS];
  aw_t  blk_len_q   [MAX_BLOCKS];
  aw_t  blk_len_d   [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] blk_vld_q, blk_vld_d;

  // command context
  logic [1:0] cmd_q, cmd_d, stat_q, stat_d;
  aw_t  size_q, size_d, tgt_q, tgt_d, key_q, key_d, addr_q, addr_d, nl_q, nl_d;
  logic zero_q, zero_d, drop_q, drop_d;
  logic [CW-1:0] idx_q, idx_d;

  // block scan accumulators
  logic bfull_q, bfull_d, inside_q, inside_d, found_q, found_d;
  logic slot_v_q, slot_v_d, slot_hit_q, slot_hit_d;
  logic [BIW-1:0] found_idx_q, found_idx_d, slot_idx_q, slot_idx_d;
  aw_t  found_len_q, found_len_d;

  // extent scan accumulators
  logic fit_v_q, fit_v_d, at_v_q, at_v_d, bt_v_q, bt_v_d, fr_v_q, fr_v_d;
  logic prv_v_q, prv_v_d, lst_v_q, lst_v_d;
  logic [EIW-1:0] fit_idx_q, fit_idx_d, at_idx_q, at_idx_d, bt_idx_q, bt_idx_d;
  logic [EIW-1:0] fr_idx_q, fr_idx_d, prv_idx_q, prv_idx_d, lst_idx_q, lst_idx_d;
  aw_t  fit_start_q, fit_start_d, fit_len_q, fit_len_d, at_len_q, at_len_d;
  aw_t  prv_start_q, prv_start_d, prv_len_q, prv_len_d;
  aw_t  lst_start_q, lst_start_d, lst_len_q, lst_len_d;

  // current scan entry
  logic [EIW-1:0] eidx;
  logic [BIW-1:0] bidx;
  aw_t  e_start, e_len, b_start, b_len, bkey;
  aw1_t e_end, b_end, akey, at_end, gb_end, lst_end;
  logic [AddrBits+1:0] bump_sum;
  logic e_vld, b_vld, scan_first, ext_scan, blk_scan, ext_last, blk_last;
  logic any_mode, at_ovf, bump_fail, fit_split, nxt_v, b_match;

  assign eidx       = idx_q[EIW-1:0];
  assign bidx       = idx_q[BIW-1:0];
  assign e_start    = ext_start_q[eidx];
  assign e_len      = ext_len_q[eidx];
  assign e_vld      = ext_vld_q[eidx];
  assign b_start    = blk_start_q[bidx];
  assign b_len      = blk_len_q[bidx];
  assign b_vld      = blk_vld_q[bidx];
  assign e_end      = {1'b0, e_start} + {1'b0, e_len};
  assign b_end      = {1'b0, b_start} + {1'b0, b_len};
  assign scan_first = (idx_q == '0);
  assign ext_last   = (idx_q == CW'(MAX_EXTENTS - 1));
  assign blk_last   = (idx_q == CW'(MAX_BLOCKS - 1));
  assign ext_scan   = (ctl_i.op inside {OP_FIT, OP_FITAT, OP_GBP, OP_GBN, OP_GBL});
  assign blk_scan   = (ctl_i.op inside {OP_BSCAN, OP_REC});
  assign bkey       = (ctl_i.op == OP_REC) ? addr_q : key_q;
  assign akey       = (ctl_i.op == OP_GBN) ? ({1'b0, key_q} + {1'b0, size_q})
                                           : {1'b0, key_q};
  assign b_match    = b_vld && (b_start == bkey);

  assign any_mode  = (cmd_q == CMD_ALLOC) || (tgt_q == '0);
  assign at_end    = {1'b0, tgt_q} + {1'b0, size_q};
  assign at_ovf    = (at_end > AddrLimit);
  assign bump_sum  = {1'b0, nfa_q} + {2'b00, size_q};
  assign bump_fail = (bump_sum > {1'b0, AddrLimit});
  assign fit_split = (fit_len_q > size_q);
  assign gb_end    = {1'b0, key_q} + {1'b0, size_q};
  assign lst_end   = {1'b0, lst_start_q} + {1'b0, lst_len_q};
  assign nxt_v     = at_v_q && !(prv_v_q && (at_idx_q == prv_idx_q));

  assign idx_d = ((ext_scan && !ext_last) || (blk_scan && !blk_last)) ?
                 idx_q + CW'(1) : '0;

  // scan accumulators
  always_comb begin
    bfull_d     = bfull_q;
    inside_d    = inside_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_len_d = found_len_q;
    slot_v_d    = slot_v_q;
    slot_hit_d  = slot_hit_q;
    slot_idx_d  = slot_idx_q;
    if (blk_scan) begin
      bfull_d  = (scan_first ? 1'b1 : bfull_q) & b_vld;
      inside_d = (scan_first ? 1'b0 : inside_q) |
                 (b_vld && (b_start == bkey ||
                            (b_start < bkey && {1'b0, bkey} < b_end)));
      found_d  = scan_first ? 1'b0 : found_q;
      slot_v_d   = scan_first ? 1'b0 : slot_v_q;
      slot_hit_d = scan_first ? 1'b0 : slot_hit_q;
      if (b_match) begin
        found_d     = 1'b1;
        found_idx_d = bidx;
        found_len_d = b_len;
      end
      if (!slot_hit_d && b_match) begin
        slot_v_d   = 1'b1;
        slot_hit_d = 1'b1;
        slot_idx_d = bidx;
      end else if (!slot_v_d && !b_vld) begin
        slot_v_d   = 1'b1;
        slot_idx_d = bidx;
      end
    end
  end

  always_comb begin
    fit_v_d = fit_v_q; fit_idx_d = fit_idx_q; fit_start_d = fit_start_q; fit_len_d = fit_len_q;
    at_v_d = at_v_q; at_idx_d = at_idx_q; at_len_d = at_len_q;
    bt_v_d = bt_v_q; bt_idx_d = bt_idx_q; fr_v_d = fr_v_q; fr_idx_d = fr_idx_q;
    prv_v_d = prv_v_q; prv_idx_d = prv_idx_q; prv_start_d = prv_start_q;
    prv_len_d = prv_len_q;
    lst_v_d = lst_v_q; lst_idx_d = lst_idx_q; lst_start_d = lst_start_q;
    lst_len_d = lst_len_q;
    case (ctl_i.op)
      OP_FIT: begin
        fit_v_d = scan_first ? 1'b0 : fit_v_q;
        if (e_vld && e_len >= size_q && (!fit_v_d || e_start < fit_start_q)) begin
          fit_v_d     = 1'b1;
          fit_idx_d   = eidx;
          fit_start_d = e_start;
          fit_len_d   = e_len;
        end
      end
      OP_FITAT, OP_GBN: begin
        at_v_d = scan_first ? 1'b0 : at_v_q;
        bt_v_d = scan_first ? 1'b0 : bt_v_q;
        fr_v_d = scan_first ? 1'b0 : fr_v_q;
        if (!at_v_d && e_vld && {1'b0, e_start} == akey) begin
          at_v_d   = 1'b1;
          at_idx_d = eidx;
          at_len_d = e_len;
        end
        if (!bt_v_d && e_vld && e_start == key_q) begin
          bt_v_d   = 1'b1;
          bt_idx_d = eidx;
        end
        if (!fr_v_d && !e_vld) begin
          fr_v_d   = 1'b1;
          fr_idx_d = eidx;
        end
      end
      OP_GBP: begin
        prv_v_d = scan_first ? 1'b0 : prv_v_q;
        if (e_vld && e_end == {1'b0, key_q} && (!prv_v_d || e_start < prv_start_q)) begin
          prv_v_d     = 1'b1;
          prv_idx_d   = eidx;
          prv_start_d = e_start;
          prv_len_d   = e_len;
        end
      end
      OP_GBL: begin
        lst_v_d = scan_first ? 1'b0 : lst_v_q;
        if (e_vld && (!lst_v_d || e_start > lst_start_q)) begin
          lst_v_d     = 1'b1;
          lst_idx_d   = eidx;
          lst_start_d = e_start;
          lst_len_d   = e_len;
        end
      end
      default: begin
      end
    endcase
  end

  // table and context updates
  always_comb begin
    nfa_d       = nfa_q;
    ext_start_d = ext_start_q;
    ext_len_d   = ext_len_q;
    ext_vld_d   = ext_vld_q;
    blk_start_d = blk_start_q;
    blk_len_d   = blk_len_q;
    blk_vld_d   = blk_vld_q;
    cmd_d  = cmd_q;
    size_d = size_q;
    tgt_d  = tgt_q;
    key_d  = key_q;
    addr_d = addr_q;
    stat_d = stat_q;
    nl_d   = nl_q;
    zero_d = zero_q;
    drop_d = drop_q;
    unique case (ctl_i.op)
      OP_LOAD: begin
        cmd_d  = cmd_i;
        tgt_d  = target_address_i;
        key_d  = target_address_i;
        zero_d = (request_size_i == '0);
        size_d = (cmd_i != CMD_RESERVE && request_size_i == '0) ?
                 aw_t'(1) : request_size_i;
        addr_d = '0;
        stat_d = ST_OK;
        drop_d = 1'b0;
      end
      OP_BDEC: begin
        if (cmd_q == CMD_RELEASE) begin
          if (!found_q) begin
            stat_d = ST_INVALID;
          end else begin
            blk_vld_d[found_idx_q] = 1'b0;
            size_d = found_len_q;
          end
        end else if (bfull_q) begin
          stat_d = ST_OOM;
        end else if (!any_mode) begin
          if (inside_q) begin
            stat_d = ST_INVALID;
          end else if (at_ovf) begin
            stat_d = ST_OOM;
          end else begin
            if (nfa_q < at_end) nfa_d = at_end;
            addr_d = tgt_q;
            blk_start_d[slot_idx_q] = tgt_q;
            blk_len_d[slot_idx_q]   = size_q;
            blk_vld_d[slot_idx_q]   = 1'b1;
          end
        end
      end
      OP_FITDEC: begin
        if (fit_v_q) begin
          addr_d = fit_start_q;
          if (fit_split) begin
            key_d = fit_start_q + size_q;
            nl_d  = fit_len_q - size_q;
          end else begin
            ext_vld_d[fit_idx_q] = 1'b0;
          end
        end else if (bump_fail) begin
          stat_d = ST_OOM;
        end else begin
          addr_d = nfa_q[AddrBits-1:0];
          nfa_d  = nfa_q + {1'b0, size_q};
        end
      end
      OP_FITW: begin
        if (at_v_q && at_idx_q != fit_idx_q) begin
          ext_len_d[at_idx_q]  = nl_q;
          ext_vld_d[fit_idx_q] = 1'b0;
        end else begin
          ext_start_d[fit_idx_q] = key_q;
          ext_len_d[fit_idx_q]   = nl_q;
        end
      end
      OP_RECW: begin
        blk_start_d[slot_idx_q] = addr_q;
        blk_len_d[slot_idx_q]   = size_q;
        blk_vld_d[slot_idx_q]   = 1'b1;
      end
      OP_GBPD: begin
        if (prv_v_q) begin
          ext_len_d[prv_idx_q] = prv_len_q + size_q;
          key_d  = prv_start_q;
          size_d = prv_len_q + size_q;
        end
      end
      OP_GBND: begin
        if (nxt_v) begin
          if (prv_v_q) begin
            ext_len_d[prv_idx_q] = size_q + at_len_q;
            ext_vld_d[at_idx_q]  = 1'b0;
          end else if (bt_v_q) begin
            ext_len_d[bt_idx_q] = size_q + at_len_q;
            ext_vld_d[at_idx_q] = 1'b0;
          end else begin
            ext_start_d[at_idx_q] = key_q;
            ext_len_d[at_idx_q]   = at_len_q + size_q;
          end
        end else if (!prv_v_q) begin
          if (bt_v_q) begin
            ext_start_d[bt_idx_q] = key_q;
            ext_len_d[bt_idx_q]   = size_q;
            ext_vld_d[bt_idx_q]   = 1'b1;
          end else if (fr_v_q) begin
            ext_start_d[fr_idx_q] = key_q;
            ext_len_d[fr_idx_q]   = size_q;
            ext_vld_d[fr_idx_q]   = 1'b1;
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      OP_GBLD: begin
        if (drop_q && (!lst_v_q || key_q > lst_start_q)) begin
          if (gb_end == nfa_q) begin
            nfa_d  = {1'b0, key_q};
            drop_d = 1'b0;
            stat_d = ST_OK;
          end else begin
            stat_d = ST_EXT_FULL;
          end
        end else begin
          stat_d = drop_q ? ST_EXT_FULL : ST_OK;
          if (lst_v_q && lst_end == nfa_q) begin
            nfa_d = {1'b0, lst_start_q};
            ext_vld_d[lst_idx_q] = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nfa_q     <= aw1_t'(1);
      ext_vld_q <= '0;
      blk_vld_q <= '0;
      idx_q     <= '0;
    end else begin
      nfa_q     <= nfa_d;
      ext_vld_q <= ext_vld_d;
      blk_vld_q <= blk_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ext_start_q <= ext_start_d;
    ext_len_q   <= ext_len_d;
    blk_start_q <= blk_start_d;
    blk_len_q   <= blk_len_d;
    cmd_q  <= cmd_d;
    size_q <= size_d;
    tgt_q  <= tgt_d;
    key_q  <= key_d;
    addr_q <= addr_d;
    stat_q <= stat_d;
    nl_q   <= nl_d;
    zero_q <= zero_d;
    drop_q <= drop_d;
    bfull_q <= bfull_d; inside_q <= inside_d; found_q <= found_d;
    found_idx_q <= found_idx_d; found_len_q <= found_len_d;
    slot_v_q <= slot_v_d; slot_hit_q <= slot_hit_d; slot_idx_q <= slot_idx_d;
    fit_v_q <= fit_v_d; fit_idx_q <= fit_idx_d;
    fit_start_q <= fit_start_d; fit_len_q <= fit_len_d;
    at_v_q <= at_v_d; at_idx_q <= at_idx_d; at_len_q <= at_len_d;
    bt_v_q <= bt_v_d; bt_idx_q <= bt_idx_d; fr_v_q <= fr_v_d; fr_idx_q <= fr_idx_d;
    prv_v_q <= prv_v_d; prv_idx_q <= prv_idx_d;
    prv_start_q <= prv_start_d; prv_len_q <= prv_len_d;
    lst_v_q <= lst_v_d; lst_idx_q <= lst_idx_d;
    lst_start_q <= lst_start_d; lst_len_q <= lst_len_d;
  end

  assign sts_o.ext_last  = ext_last;
  assign sts_o.blk_last  = blk_last;
  assign sts_o.cmd       = cmd_q;
  assign sts_o.size_zero = zero_q;
  assign sts_o.any_mode  = any_mode;
  assign sts_o.blk_full  = bfull_q;
  assign sts_o.found     = found_q;
  assign sts_o.fit_hit   = fit_v_q;
  assign sts_o.fit_split = fit_split;
  assign sts_o.bump_fail = bump_fail;

  assign result_address_o = addr_q;
  assign status_o         = stat_q;

  `FFEA_ASSERT(a_nfa_range, clk_i, rst_ni, nfa_q <= AddrLimit, "bump pointer past limit")

endmodule

[rtl/core/first_fit_extent_allocator_core.sv]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core
// first fit allocator over free extents, live blocks and a bump pointer
// ----------------------------------------------------------------------------
// order of work: a reserve of size zero goes straight to done; release and allocate scan
//   the block table first and then the extent table
// throughput: one command word at a time, set by one-entry-per-cycle table scans
// the done strobe lasts one cycle and cannot be stalled; busy drops right after
// reset empties both tables and sets the bump pointer to 1, no clearing pass
`timescale 1ns / 1ps

module first_fit_extent_allocator_core
  import ffea_pkg::*;
#(
  parameter int unsigned MAX_EXTENTS = DefMaxExtents,
  parameter int unsigned MAX_BLOCKS  = DefMaxBlocks
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // command word, taken when start is high and busy is low
  input  logic       start,
  input  logic [1:0] cmd_i,
  input  aw_t        request_size_i,
  input  aw_t        target_address_i,
  output logic       busy,
  // result word, valid for the single cycle that done_o is high
  output logic       done_o,
  output aw_t        result_address_o,
  output logic [1:0] status_o
);

  // controller to datapath micro operation and the flags it branches on
  dp_ctl_t ctl;
  dp_sts_t sts;

  // state machine: dispatch, block scan, fit scan, record and merge steps
  ffea_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .ctl_o   (ctl),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  // tables in flops, scanned through a single index one entry per cycle
  ffea_datapath #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .MAX_BLOCKS  (MAX_BLOCKS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd_i),
    .request_size_i   (request_size_i),
    .target_address_i (target_address_i),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .result_address_o (result_address_o),
    .status_o         (status_o)
  );

endmodule

[test/first_fit_extent_allocator_core_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_core_tb
// drives allocate, allocate-at, release and reserve words into the allocator,
// predicts each result word from a local copy of the extent and block tables,
// and compares address and status field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module first_fit_extent_allocator_core_tb;
  import ffea_pkg::*;

  localparam int NumExt   = 16;
  localparam int NumBlk   = 32;
  localparam int NumRand  = 500;
  localparam int MaxCyc   = 400000;
  localparam logic [32:0] AddrTop = 33'h1_0000_0000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic [1:0] cmd_i = CMD_ALLOC;
  aw_t        request_size_i = '0;
  aw_t        target_address_i = '0;
  logic       busy;
  logic       done_o;
  aw_t        result_address_o;
  logic [1:0] status_o;

  first_fit_extent_allocator_core dut (
    .clk_i, .rst_ni, .start, .cmd_i, .request_size_i, .target_address_i,
    .busy, .done_o, .result_address_o, .status_o
  );

  always #5 clk_i = ~clk_i;

  // predictor state, 33-bit arithmetic so nothing wraps
  logic [32:0] bump_ptr;
  logic [32:0] ext_base [NumExt];
  logic [32:0] ext_len  [NumExt];
  logic        ext_live [NumExt];
  logic [32:0] blk_base [NumBlk];
  logic [32:0] blk_len  [NumBlk];
  logic        blk_live [NumBlk];

  typedef struct packed {
    aw_t        addr;
    logic [1:0] st;
  } grant_t;

  grant_t pending_grants[$];
  int     errors = 0;
  int     words_done = 0;
  int     cyc = 0;
  int     send_idle_pct = 0;
  aw_t    live_addrs[$];

  function automatic int ext_find(logic [32:0] s);
    for (int i = 0; i < NumExt; i++)
      if (ext_live[i] && ext_base[i] == s) return i;
    return -1;
  endfunction

  function automatic bit carve_fit(logic [32:0] sz, output logic [32:0] a);
    int b;
    int d;
    b = -1;
    a = '0;
    for (int i = 0; i < NumExt; i++)
      if (ext_live[i] && ext_len[i] >= sz && (b < 0 || ext_base[i] < ext_base[b])) b = i;
    if (b < 0) return 0;
    a = ext_base[b];
    if (ext_len[b] > sz) begin
      d = ext_find(ext_base[b] + sz);
      if (d >= 0 && d != b) begin
        ext_len[d] = ext_len[b] - sz;
        ext_live[b] = 0;
      end else begin
        ext_len[b] = ext_len[b] - sz;
        ext_base[b] = ext_base[b] + sz;
      end
    end else begin
      ext_live[b] = 0;
    end
    return 1;
  endfunction

  function automatic bit take_bump(logic [32:0] sz, output logic [32:0] a);
    a = '0;
    if (bump_ptr > AddrTop || sz > AddrTop - bump_ptr) return 0;
    a = bump_ptr;
    bump_ptr = bump_ptr + sz;
    return 1;
  endfunction

  function automatic void note_block(logic [32:0] a, logic [32:0] len);
    int slot;
    slot = -1;
    for (int i = 0; i < NumBlk; i++) begin
      if (blk_live[i] && blk_base[i] == a) begin
        slot = i;
        break;
      end
      if (!blk_live[i] && slot < 0) slot = i;
    end
    if (slot < 0) return;
    blk_base[slot] = a;
    blk_len[slot] = len;
    blk_live[slot] = 1;
  endfunction

  // returns the freed extent, merging with neighbours and retracting the bump pointer
  function automatic logic [1:0] return_extent(logic [32:0] v, logic [32:0] sz);
    int  p;
    int  n;
    int  d;
    int  top;
    bit  lost;
    p = -1;
    top = -1;
    lost = 0;
    for (int i = 0; i < NumExt; i++)
      if (ext_live[i] && ext_base[i] + ext_len[i] == v && (p < 0 || ext_base[i] < ext_base[p]))
        p = i;
    if (p >= 0) begin
      ext_len[p] = ext_len[p] + sz;
      v = ext_base[p];
      sz = ext_len[p];
    end
    n = ext_find(v + sz);
    if (n == p) n = -1;
    if (n >= 0) begin
      if (p >= 0) begin
        ext_len[p] = ext_len[p] + ext_len[n];
        ext_live[n] = 0;
      end else begin
        d = ext_find(v);
        if (d >= 0) begin
          ext_len[d] = sz + ext_len[n];
          ext_live[n] = 0;
        end else begin
          ext_base[n] = v;
          ext_len[n] = ext_len[n] + sz;
        end
      end
    end else if (p < 0) begin
      d = ext_find(v);
      if (d < 0)
        for (int i = 0; i < NumExt; i++)
          if (!ext_live[i]) begin
            d = i;
            break;
          end
      if (d >= 0) begin
        ext_base[d] = v;
        ext_len[d] = sz;
        ext_live[d] = 1;
      end else begin
        lost = 1;
      end
    end
    for (int i = 0; i < NumExt; i++)
      if (ext_live[i] && (top < 0 || ext_base[i] > ext_base[top])) top = i;
    if (lost && (top < 0 || v > ext_base[top])) begin
      if (v + sz == bump_ptr) begin
        bump_ptr = v;
        lost = 0;
      end
    end else if (top >= 0 && ext_base[top] + ext_len[top] == bump_ptr) begin
      bump_ptr = ext_base[top];
      ext_live[top] = 0;
    end
    return lost ? ST_EXT_FULL : ST_OK;
  endfunction

  function automatic grant_t predict_grant(logic [1:0] c, aw_t rsz, aw_t tgt);
    grant_t      g;
    logic [32:0] a;
    logic [32:0] eff;
    logic [32:0] t;
    int          cnt;
    int          hit;
    bit          overlap;
    g.addr = '0;
    g.st = ST_OK;
    a = '0;
    t = {1'b0, tgt};
    eff = (rsz == 0) ? 33'd1 : {1'b0, rsz};
    cnt = 0;
    hit = -1;
    overlap = 0;
    for (int i = 0; i < NumBlk; i++) if (blk_live[i]) cnt++;
    case (c)
      CMD_ALLOC, CMD_ALLOC_AT: begin
        if (cnt >= NumBlk) begin
          g.st = ST_OOM;
        end else if (c == CMD_ALLOC || tgt == 0) begin
          if (!carve_fit(eff, a) && !take_bump(eff, a)) g.st = ST_OOM;
          else note_block(a, eff);
        end else begin
          for (int i = 0; i < NumBlk; i++)
            if (blk_live[i] && (blk_base[i] == t ||
                (blk_base[i] < t && t < blk_base[i] + blk_len[i]))) overlap = 1;
          if (overlap) g.st = ST_INVALID;
          else if (eff > AddrTop - t) g.st = ST_OOM;
          else begin
            if (bump_ptr < t + eff) bump_ptr = t + eff;
            a = t;
            note_block(a, eff);
          end
        end
      end
      CMD_RELEASE: begin
        for (int i = 0; i < NumBlk; i++)
          if (blk_live[i] && blk_base[i] == t) hit = i;
        if (hit < 0) g.st = ST_INVALID;
        else begin
          g.st = return_extent(blk_base[hit], blk_len[hit]);
          blk_live[hit] = 0;
        end
      end
      default: begin
        if (rsz != 0 && !carve_fit({1'b0, rsz}, a) && !take_bump({1'b0, rsz}, a))
          g.st = ST_OOM;
      end
    endcase
    if (g.st == ST_OK) g.addr = a[31:0];
    return g;
  endfunction

  // directed rows; chk marks rows whose result is typed in
  typedef struct {
    logic [1:0] c;
    aw_t        sz;
    aw_t        tgt;
    bit         chk;
    aw_t        ea;
    logic [1:0] est;
  } row_t;

  row_t rows[] = '{
    '{CMD_RELEASE,  32'd0,          32'd0,          1, 32'd0, ST_INVALID},
    '{CMD_RESERVE,  32'd0,          32'd0,          1, 32'd0, ST_OK},
    '{CMD_ALLOC,    32'd0,          32'd0,          1, 32'd1, ST_OK},
    '{CMD_ALLOC,    32'd16,         32'd0,          1, 32'd2, ST_OK},
    '{CMD_ALLOC,    32'hFFFF_FFFF,  32'd0,          1, 32'd0, ST_OOM},
    '{CMD_ALLOC_AT, 32'd8,          32'd5,          1, 32'd0, ST_INVALID},
    '{CMD_ALLOC_AT, 32'd4,          32'd0,          0, 32'd0, ST_OK},
    '{CMD_ALLOC_AT, 32'd2,          32'hFFFF_FFFF,  1, 32'd0, ST_OOM},
    '{CMD_ALLOC_AT, 32'd1,          32'hFFFF_FFFF,  1, 32'hFFFF_FFFF, ST_OK},
    '{CMD_ALLOC_AT, 32'd16,         32'd100,        1, 32'd100, ST_OK},
    '{CMD_RELEASE,  32'hFFFF_FFFF,  32'd2,          1, 32'd0, ST_OK},
    '{CMD_ALLOC,    32'd4,          32'd0,          0, 32'd0, ST_OK},
    '{CMD_RESERVE,  32'd3,          32'd0,          0, 32'd0, ST_OK},
    '{CMD_RESERVE,  32'hFFFF_FFFF,  32'd0,          1, 32'd0, ST_OOM},
    '{CMD_RELEASE,  32'd0,          32'd3,          1, 32'd0, ST_INVALID},
    '{CMD_RELEASE,  32'd0,          32'hFFFF_FFFF,  0, 32'd0, ST_OK},
    '{CMD_RELEASE,  32'd0,          32'd100,        0, 32'd0, ST_OK},
    '{CMD_RELEASE,  32'd0,          32'd1,          0, 32'd0, ST_OK}
  };

  // result checker on the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cyc <= cyc + 1;
      if (done_o) begin
        words_done <= words_done + 1;
        if (pending_grants.size() == 0) begin
          $display("%0t: unexpected result word addr=%h status=%0d",
                   $time, result_address_o, status_o);
          errors = errors + 1;
        end else begin
          if (result_address_o !== pending_grants[0].addr) begin
            $display("%0t: address mismatch expected %h actual %h",
                     $time, pending_grants[0].addr, result_address_o);
            errors = errors + 1;
          end
          if (status_o !== pending_grants[0].st) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, pending_grants[0].st, status_o);
            errors = errors + 1;
          end
          void'(pending_grants.pop_front());
        end
      end
      if (cyc >= MaxCyc) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // hands one word over at the falling edge once busy is low; it is taken at
  // the next rising edge
  task automatic send_word(logic [1:0] c, aw_t sz, aw_t tgt, bit typed, grant_t want);
    grant_t g;
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    while (busy) @(negedge clk_i);
    cmd_i <= c;
    request_size_i <= sz;
    target_address_i <= tgt;
    start <= 1'b1;
    @(posedge clk_i);
    g = predict_grant(c, sz, tgt);
    if (typed && g != want)
      $display("%0t: typed row disagrees with prediction %h/%0d", $time, want.addr, want.st);
    pending_grants.push_back(typed ? want : g);
    if (c != CMD_RELEASE && g.st == ST_OK && c != CMD_RESERVE) live_addrs.push_back(g.addr);
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic drain();
    while (pending_grants.size() != 0) @(negedge clk_i);
  endtask

  function automatic aw_t pick_size();
    int k;
    k = $urandom_range(99);
    if (k < 70) return $urandom_range(64);
    if (k < 90) return $urandom_range(4096);
    if (k < 97) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(3);
  endfunction

  task automatic random_word();
    int    k;
    int    j;
    aw_t   tgt;
    aw_t   sz;
    k = $urandom_range(99);
    sz = pick_size();
    tgt = $urandom;
    if (live_addrs.size() != 0 && $urandom_range(99) < 70) begin
      j = $urandom_range(live_addrs.size() - 1);
      tgt = live_addrs[j] + aw_t'(($urandom_range(9) == 0) ? $urandom_range(3) : 0);
      if (k >= 35 && k < 70) live_addrs.delete(j);
    end else if ($urandom_range(1)) begin
      tgt = $urandom_range(2000);
    end
    if (k < 35) send_word(CMD_ALLOC, sz, tgt, 0, '0);
    else if (k < 70) send_word(CMD_RELEASE, sz, tgt, 0, '0);
    else if (k < 85) send_word(CMD_ALLOC_AT, sz, ($urandom_range(9) == 0) ? '0 : tgt, 0, '0);
    else send_word(CMD_RESERVE, sz, tgt, 0, '0);
  endtask

  initial begin
    grant_t want;
    bump_ptr = 33'd1;
    for (int i = 0; i < NumExt; i++) ext_live[i] = 0;
    for (int i = 0; i < NumBlk; i++) blk_live[i] = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (rows[i]) begin
      want.addr = rows[i].ea;
      want.st = rows[i].est;
      send_word(rows[i].c, rows[i].sz, rows[i].tgt, rows[i].chk, want);
    end
    drain();
    live_addrs.delete();

    // fill the block table to the brim, then walk fragmentation and free space
    for (int i = 0; i < 34; i++) send_word(CMD_ALLOC, $urandom_range(1, 8), '0, 0, '0);
    for (int i = 0; i < 34; i += 2)
      if (i < live_addrs.size()) send_word(CMD_RELEASE, '0, live_addrs[i], 0, '0);
    drain();
    live_addrs.delete();

    // random phases with changing sender idle rates
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 54 : 0;
      for (int n = 0; n < NumRand / 3; n++) begin
        random_word();
        if (n == 40) drain();
      end
    end

    drain();
    repeat (200) @(negedge clk_i);
    $display("covered directed extremes, full block table and %0d result words", words_done);
    $display("random allocate, allocate-at, release and reserve under three idle rates");
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
